>>> sv/gradient_palette_sampler_macros.svh
// assertion macros for the gradient palette sampler
// used by gps_front and gps_back, no other dependencies
`ifndef GRADIENT_PALETTE_SAMPLER_MACROS_SVH
`define GRADIENT_PALETTE_SAMPLER_MACROS_SVH

// same-cycle implication
`define GPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gps assertion failed");

// next-cycle implication
`define GPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gps assertion failed");

`endif

>>> sv/gps_pkg.sv
// shared types, constants and helpers of the gradient palette sampler
// no dependencies
package gps_pkg;

    localparam int DEF_MAX_STOPS    = 16;
    localparam int DEF_CHANNEL_BITS = 16;
    localparam int CH_W             = 16;
    localparam int CNT_W            = 5;
    localparam int IN_DATA_W        = 120;
    localparam int OUT_DATA_W       = 88;

    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [16:0] HALF_Q16       = 17'd32768;
    localparam logic [16:0] EPS_Q16        = 17'd7;
    localparam logic [16:0] HARD_WIDTH_Q16 = 17'd65;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SAMPLE = 1'b1
    } t_kind;

    // one queued request; pos is the stop position or the sample position
    typedef struct packed {
        t_kind        kind;
        logic [3:0]   idx;
        logic [16:0]  pos;
        logic [16:0]  wid;
        logic [63:0]  col;
    } t_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DIV_BLEND,
        ST_MUL_W0,
        ST_MUL_W1,
        ST_WEIGHT,
        ST_DIV_STEP,
        ST_SQUARE,
        ST_POLY_LO,
        ST_POLY_HI,
        ST_MUL_C0,
        ST_MUL_C1,
        ST_DONE
    } t_state;

    function automatic logic [16:0] sat_one(input logic [16:0] v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

>>> sv/gps_front.sv
// front end: accepts requests, classifies and saturates them, two-entry queue
// depends on gps_pkg and gradient_palette_sampler_macros.svh
`include "gradient_palette_sampler_macros.svh"
module gps_front #(
    parameter int CHANNEL_BITS = gps_pkg::DEF_CHANNEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [gps_pkg::IN_DATA_W-1:0]  i_data,
    input  logic                           i_pop,
    output logic                           o_head_valid,
    output gps_pkg::t_req                  o_head
);
    import gps_pkg::*;

    localparam logic [CH_W-1:0] CH_MASK = CH_W'((32'd1 << CHANNEL_BITS) - 32'd1);

    t_req       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    t_req       w_req;
    logic       w_push;

    always_comb begin
        w_req.kind = t_kind'(i_cmd);
        w_req.idx  = i_data[3:0];
        if (w_req.kind == KIND_SAMPLE) begin
            w_req.pos = sat_one(i_data[118:102]);
        end else begin
            w_req.pos = sat_one(i_data[20:4]);
        end
        w_req.wid  = sat_one(i_data[37:21]);
        w_req.col  = {i_data[101:86] & CH_MASK, i_data[85:70] & CH_MASK,
                      i_data[69:54] & CH_MASK, i_data[53:38] & CH_MASK};
    end

    assign o_ready      = (r_cnt != 2'd2);
    assign w_push       = i_valid && o_ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_req;
        end
    end

    `GPS_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_cnt != 2'd0)
    `GPS_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
    `GPS_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, w_push && !i_pop, r_cnt == $past(r_cnt) + 2'd1)

endmodule

>>> sv/gps_back.sv
// back end: stop table, bracket search, divider and multiply sequencer, result register
// depends on gps_pkg and gradient_palette_sampler_macros.svh
`include "gradient_palette_sampler_macros.svh"
module gps_back #(
    parameter int MAX_STOPS = gps_pkg::DEF_MAX_STOPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gps_pkg::CNT_W-1:0]       i_cfg_wdata,
    input  logic                            i_head_valid,
    input  gps_pkg::t_req                   i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gps_pkg::OUT_DATA_W-1:0]  o_data
);
    import gps_pkg::*;

    localparam int AW = $clog2(MAX_STOPS);
    localparam int NW = $clog2(MAX_STOPS + 1);

    logic [16:0] mem_pos [MAX_STOPS];
    logic [16:0] mem_wid [MAX_STOPS];
    logic [63:0] mem_col [MAX_STOPS];

    t_state      r_state, n_state;
    logic [CNT_W-1:0] r_stop_count;
    logic [NW-1:0] r_n, n_n;
    logic [AW-1:0] r_idx, n_idx;
    logic [16:0] r_p, n_p;
    logic [16:0] r_rd_pos, r_rd_wid;
    logic [63:0] r_rd_col;
    logic [16:0] r_pv_pos, n_pv_pos, r_pv_wid, n_pv_wid;
    logic [63:0] r_pv_col, n_pv_col;
    logic [18:0] r_rem, n_rem;
    logic [17:0] r_den, n_den;
    logic [16:0] r_quo, n_quo;
    logic [4:0]  r_dcnt, n_dcnt;
    logic [16:0] r_b, n_b;
    logic [33:0] r_acc, n_acc;
    logic [16:0] r_s, n_s;
    logic [16:0] r_v, n_v;
    logic [33:0] r_vv, n_vv;
    logic [34:0] r_plo, n_plo;
    logic [16:0] r_f, n_f;
    logic [1:0]  r_ch, n_ch;
    logic [63:0] r_res_col, n_res_col;
    logic [16:0] r_res_s, n_res_s;
    logic        r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    logic [NW-1:0] w_cnt_sat;
    logic        w_wr_ok;
    logic        w_rd;
    logic        w_ge;
    logic [18:0] w_rem_sub;
    logic [16:0] w_quo_step;
    logic        w_div_last;
    logic        w_brk;
    logic        w_last;
    logic [16:0] w_diff;
    logic        w_hard;
    logic [19:0] w_num;
    logic        w_num_le0;
    logic        w_num_sat;
    logic [17:0] w_t;
    logic [34:0] w_phi;
    logic [51:0] w_tot;
    logic [15:0] w_c0, w_c1;
    logic [33:0] w_csum;
    logic [33:0] w_wsum;
    logic        w_out_free;

    assign w_cnt_sat = (32'(r_stop_count) > MAX_STOPS) ? NW'(MAX_STOPS) : NW'(r_stop_count);
    assign o_pop     = (r_state == ST_IDLE) && i_head_valid;
    assign w_wr_ok   = o_pop && (i_head.kind == KIND_WRITE) && (32'(i_head.idx) < MAX_STOPS);
    assign w_rd      = (r_state == ST_READ);

    // one restoring step: compare, subtract, shift for the next bit
    assign w_ge       = (r_rem >= {1'b0, r_den});
    assign w_rem_sub  = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;
    assign w_quo_step = {r_quo[15:0], w_ge};
    assign w_div_last = (r_dcnt == 5'd0);

    assign w_brk  = (r_idx != '0) && (r_p >= r_pv_pos) && (r_p <= r_rd_pos);
    assign w_last = ((NW'(r_idx) + NW'(1)) == r_n);
    assign w_diff = r_rd_pos - r_pv_pos;

    assign w_hard    = (r_s <= HARD_WIDTH_Q16);
    assign w_num     = {2'b00, r_b, 1'b0} + {3'b000, r_s} - 20'd65536;
    assign w_num_le0 = w_num[19] || (w_num == 20'd0);
    assign w_num_sat = (w_num[18:0] >= {r_s, 2'b00} >> 1);

    assign w_t    = 18'd196608 - {r_v, 1'b0};
    assign w_phi  = 35'(r_vv[33:17]) * 35'(w_t);
    assign w_tot  = {w_phi, 17'd0} + 52'(r_plo);
    assign w_wsum = r_acc + 34'(r_rd_wid) * 34'(r_b);

    assign w_c0   = r_pv_col[16*r_ch +: 16];
    assign w_c1   = r_rd_col[16*r_ch +: 16];
    assign w_csum = r_acc + 34'(w_c1) * 34'(r_f);

    assign w_out_free = !r_ovalid || i_ready;
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_head.kind == KIND_SAMPLE) begin
                    n_state = (w_cnt_sat == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:      n_state = ST_CHECK;
            ST_CHECK: begin
                if (w_brk) begin
                    n_state = ST_DIV_BLEND;
                end else if (w_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_DIV_BLEND: n_state = w_div_last ? ST_MUL_W0 : ST_DIV_BLEND;
            ST_MUL_W0:    n_state = ST_MUL_W1;
            ST_MUL_W1:    n_state = ST_WEIGHT;
            ST_WEIGHT: begin
                if (w_hard) begin
                    n_state = ST_MUL_C0;
                end else if (w_num_le0 || w_num_sat) begin
                    n_state = ST_SQUARE;
                end else begin
                    n_state = ST_DIV_STEP;
                end
            end
            ST_DIV_STEP:  n_state = w_div_last ? ST_SQUARE : ST_DIV_STEP;
            ST_SQUARE:    n_state = ST_POLY_LO;
            ST_POLY_LO:   n_state = ST_POLY_HI;
            ST_POLY_HI:   n_state = ST_MUL_C0;
            ST_MUL_C0:    n_state = ST_MUL_C1;
            ST_MUL_C1:    n_state = (r_ch == 2'd3) ? ST_DONE : ST_MUL_C0;
            ST_DONE:      n_state = w_out_free ? ST_IDLE : ST_DONE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_n       = r_n;
        n_idx     = r_idx;
        n_p       = r_p;
        n_pv_pos  = r_pv_pos;
        n_pv_wid  = r_pv_wid;
        n_pv_col  = r_pv_col;
        n_rem     = r_rem;
        n_den     = r_den;
        n_quo     = r_quo;
        n_dcnt    = r_dcnt;
        n_b       = r_b;
        n_acc     = r_acc;
        n_s       = r_s;
        n_v       = r_v;
        n_vv      = r_vv;
        n_plo     = r_plo;
        n_f       = r_f;
        n_ch      = r_ch;
        n_res_col = r_res_col;
        n_res_s   = r_res_s;
        n_ovalid  = r_ovalid && !i_ready;
        n_odata   = r_odata;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_head.kind == KIND_SAMPLE) begin
                    n_p       = i_head.pos;
                    n_n       = w_cnt_sat;
                    n_idx     = '0;
                    n_res_col = 64'd0;
                    n_res_s   = HALF_Q16;
                end
            end
            ST_CHECK: begin
                if (w_brk) begin
                    n_rem  = {2'b00, r_p - r_pv_pos};
                    n_den  = {1'b0, (w_diff < EPS_Q16) ? EPS_Q16 : w_diff};
                    n_quo  = 17'd0;
                    n_dcnt = 5'd16;
                end else if (w_last) begin
                    n_res_col = r_rd_col;
                    n_res_s   = r_rd_wid;
                end else begin
                    n_pv_pos = r_rd_pos;
                    n_pv_wid = r_rd_wid;
                    n_pv_col = r_rd_col;
                    n_idx    = r_idx + AW'(1);
                end
            end
            ST_DIV_BLEND, ST_DIV_STEP: begin
                n_rem  = {w_rem_sub[17:0], 1'b0};
                n_quo  = w_quo_step;
                n_dcnt = r_dcnt - 5'd1;
                if (w_div_last) begin
                    if (r_state == ST_DIV_BLEND) begin
                        n_b = w_quo_step;
                    end else begin
                        n_v = w_quo_step;
                    end
                end
            end
            ST_MUL_W0: n_acc = 34'(r_pv_wid) * 34'(ONE_Q16 - r_b);
            ST_MUL_W1: begin
                n_s     = w_wsum[32:16];
                n_res_s = w_wsum[32:16];
            end
            ST_WEIGHT: begin
                n_ch = 2'd0;
                if (w_hard) begin
                    n_f = (r_b < HALF_Q16) ? 17'd0 : ONE_Q16;
                end else if (w_num_le0) begin
                    n_v = 17'd0;
                end else if (w_num_sat) begin
                    n_v = ONE_Q16;
                end else begin
                    n_rem  = {1'b0, w_num[17:0]};
                    n_den  = {r_s, 1'b0};
                    n_quo  = 17'd0;
                    n_dcnt = 5'd16;
                end
            end
            ST_SQUARE:  n_vv  = 34'(r_v) * 34'(r_v);
            ST_POLY_LO: n_plo = 35'(r_vv[16:0]) * 35'(w_t);
            ST_POLY_HI: begin
                n_f  = w_tot[48:32];
                n_ch = 2'd0;
            end
            ST_MUL_C0: n_acc = 34'(w_c0) * 34'(ONE_Q16 - r_f);
            ST_MUL_C1: begin
                n_res_col[16*r_ch +: 16] = w_csum[31:16];
                n_ch = r_ch + 2'd1;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = {7'd0, r_res_s, r_res_col};
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_stop_count <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_stop_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_idx     <= n_idx;
        r_p       <= n_p;
        r_pv_pos  <= n_pv_pos;
        r_pv_wid  <= n_pv_wid;
        r_pv_col  <= n_pv_col;
        r_rem     <= n_rem;
        r_den     <= n_den;
        r_quo     <= n_quo;
        r_dcnt    <= n_dcnt;
        r_b       <= n_b;
        r_acc     <= n_acc;
        r_s       <= n_s;
        r_v       <= n_v;
        r_vv      <= n_vv;
        r_plo     <= n_plo;
        r_f       <= n_f;
        r_ch      <= n_ch;
        r_res_col <= n_res_col;
        r_res_s   <= n_res_s;
        r_odata   <= n_odata;
    end

    // stop table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            mem_pos[AW'(i_head.idx)] <= i_head.pos;
            mem_wid[AW'(i_head.idx)] <= i_head.wid;
            mem_col[AW'(i_head.idx)] <= i_head.col;
        end
        if (w_rd) begin
            r_rd_pos <= mem_pos[r_idx];
            r_rd_wid <= mem_wid[r_idx];
            r_rd_col <= mem_col[r_idx];
        end
    end

    `GPS_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE)
    `GPS_ASSERT_NEXT(a_check_after_read, i_clk, i_rst_n, r_state == ST_READ, r_state == ST_CHECK)
    `GPS_ASSERT_NOW(a_blend_bounded, i_clk, i_rst_n, r_state == ST_MUL_W0, r_b <= ONE_Q16)

endmodule

>>> sv/gradient_palette_sampler.sv
// top level of the gradient palette sampler: stream ports, front queue and back sequencer
// depends on gps_pkg, gps_front and gps_back
//
// Colour gradient lookup over a table of up to MAX_STOPS stops (position,
// smoothness, RGBA). A request with tuser 0 writes one stop and produces no
// response; a request with tuser 1 samples the gradient at a clamped
// position and produces one response. The front queue holds two requests,
// so the input can go on accepting, until the queue is full, while the back
// end works or the output stalls. A write is taken while the back end is
// idle. A sample reads the stop table one stop at a time through its
// single read port until it finds its bracketing pair (or falls back to
// the last stop), then runs the iterative blend divider, the smoothstep
// divider (skipped for a hard step or a clamped weight) and the
// multiplies, besides the pop, the weight test and the output register.
// stop_count is set through i_cfg_we/i_cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce;
// values above MAX_STOPS act as MAX_STOPS. Table entries have no reset and
// must be written before a sample reaches them.
module gradient_palette_sampler #(
    parameter int MAX_STOPS    = gps_pkg::DEF_MAX_STOPS,
    parameter int CHANNEL_BITS = gps_pkg::DEF_CHANNEL_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // stop_index[3:0], stop_position[20:4], stop_smoothness[37:21],
    // stop_red[53:38], stop_green[69:54], stop_blue[85:70],
    // stop_alpha[101:86], sample_pos[118:102], zero pad [119]
    input  logic [gps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  logic                            s_axis_tuser,
    // response stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48],
    // smoothness_out[80:64], zero pad [87:81]
    output logic [gps_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // stop_count register write
    input  logic                            i_cfg_we,
    input  logic [gps_pkg::CNT_W-1:0]       i_cfg_wdata
);
    import gps_pkg::*;

    // queue head handed to the back end
    t_req w_head;
    logic w_head_valid;
    logic w_pop;

    // accepts, saturates positions, masks colour channels, queues
    gps_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // table writes, bracket search, blend math, output register
    gps_back #(
        .MAX_STOPS (MAX_STOPS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata)
    );

endmodule
